/* src/mslt_pkg.sv */
`timescale 1ns / 1ps
package mslt_pkg;

	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_APPEND = 3'd1;
	localparam logic [2:0] REQ_DROP   = 3'd2;
	localparam logic [2:0] REQ_DELETE = 3'd3;
	localparam logic [2:0] REQ_READ   = 3'd4;
	localparam logic [2:0] REQ_SORTED = 3'd5;
	localparam logic [2:0] REQ_COUNT  = 3'd6;
	localparam logic [2:0] REQ_RESIZE = 3'd7;

	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_EXISTS       = 4'd1;
	localparam logic [3:0] ST_BAD_SLOT     = 4'd2;
	localparam logic [3:0] ST_NO_MEM       = 4'd3;
	localparam logic [3:0] ST_BAD_SIZE     = 4'd4;
	localparam logic [3:0] ST_FULL         = 4'd5;
	localparam logic [3:0] ST_NO_SLOT      = 4'd6;
	localparam logic [3:0] ST_EMPTY        = 4'd7;
	localparam logic [3:0] ST_NOT_FOUND    = 4'd8;
	localparam logic [3:0] ST_BAD_NEW_SIZE = 4'd9;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [3:0]         slot_number;
		logic signed [15:0] size_or_delta;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [3:0]         status;
		logic signed [31:0] data_word;
		logic [4:0]         fill_count;
		logic               last_result;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_SINGLE,
		CMD_READ,
		CMD_READ_NEXT,
		CMD_CMP,
		CMD_SHIFT,
		CMD_DEL_DONE,
		CMD_NOT_FOUND,
		CMD_EMIT_SEQ,
		CMD_SORT_CMP,
		CMD_SORT_EMIT
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       multi;
		logic       i_end;
		logic       i_next_end;
		logic       found;
		logic       k_end;
		logic       out_free;
	} dp_stat_t;

endpackage

/* src/mslt_dp.sv */
`timescale 1ns / 1ps
module mslt_dp
	import mslt_pkg::*;
#(
	parameter int NUM_SLOTS = 10,
	parameter int SLOT_CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  logic     rsp_stall,
	output logic     rsp_valid,
	output rsp_t     rsp
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(SLOT_CAPACITY + 1);
	localparam int DEPTH = NUM_SLOTS * SLOT_CAPACITY;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [17:0] CAP_S = 18'(SLOT_CAPACITY);

	req_t                req_q;
	logic                exists_q [NUM_SLOTS];
	logic [CW-1:0]       size_q [NUM_SLOTS];
	logic [CW-1:0]       fill_q [NUM_SLOTS];
	logic [CW-1:0]       i_q, k_q;
	logic signed [31:0]  rd_q, best_v_q, last_v_q;
	logic [CW-1:0]       best_i_q, last_i_q;
	logic                best_ok_q, has_last_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic signed [31:0]  mem [DEPTH];

	logic                bad_slot, ex;
	logic [IW-1:0]       idx;
	logic [CW-1:0]       sz, fl;
	logic signed [17:0]  sd18, ns;
	logic [3:0]          st;
	logic [CW-1:0]       fill_o, new_fill, new_size;
	logic                do_create, do_fill, do_size, do_app;
	logic                is_emit, cand, better;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic                mem_we;
	logic signed [31:0]  wr_data;
	logic [31:0]         fw;

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] s, input logic [CW-1:0] o);
		return AW'(32'(s) * SLOT_CAPACITY + 32'(o));
	endfunction

	always_comb begin
		bad_slot = (req_q.slot_number == 4'd0) || (32'(req_q.slot_number) > NUM_SLOTS);
		idx = IW'(req_q.slot_number - 4'd1);
		ex = !bad_slot && exists_q[idx];
		sz = size_q[idx];
		fl = fill_q[idx];
		sd18 = 18'(req_q.size_or_delta);
		ns = 18'($signed({1'b0, sz})) + sd18;
	end

	always_comb begin
		st = ST_OK;
		fill_o = '0;
		new_fill = fl;
		new_size = sz;
		do_create = 1'b0;
		do_fill = 1'b0;
		do_size = 1'b0;
		do_app = 1'b0;
		if (bad_slot) begin
			st = ST_BAD_SLOT;
		end else if (req_q.req_type == REQ_CREATE) begin
			if (ex) begin
				st = ST_EXISTS;
				fill_o = fl;
			end else if (sd18 < 18'sd1) begin
				st = ST_BAD_SIZE;
			end else if (sd18 > CAP_S) begin
				st = ST_NO_MEM;
			end else begin
				do_create = 1'b1;
			end
		end else if (!ex) begin
			st = ST_NO_SLOT;
		end else begin
			case (req_q.req_type)
				REQ_APPEND: begin
					if (fl < sz) begin
						do_app = 1'b1;
						do_fill = 1'b1;
						new_fill = fl + 1'b1;
						fill_o = new_fill;
					end else begin
						st = ST_FULL;
						fill_o = fl;
					end
				end
				REQ_DROP, REQ_DELETE: begin
					if (fl == '0) begin
						st = ST_EMPTY;
					end else begin
						do_fill = 1'b1;
						new_fill = fl - 1'b1;
						fill_o = new_fill;
					end
				end
				REQ_COUNT: begin
					st = (fl == '0) ? ST_EMPTY : ST_OK;
					fill_o = fl;
				end
				REQ_RESIZE: begin
					fill_o = fl;
					if (ns < 18'sd1) begin
						st = ST_BAD_NEW_SIZE;
					end else if (ns > CAP_S) begin
						st = ST_NO_MEM;
					end else begin
						do_size = 1'b1;
						new_size = CW'(ns);
						do_fill = 1'b1;
						new_fill = (fl > CW'(ns)) ? CW'(ns) : fl;
						fill_o = new_fill;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cand = !has_last_q || (rd_q > last_v_q) || (rd_q == last_v_q && i_q > last_i_q);
		better = !best_ok_q || (rd_q < best_v_q);
		is_emit = (cmd == CMD_SINGLE) || (cmd == CMD_DEL_DONE) || (cmd == CMD_NOT_FOUND)
			|| (cmd == CMD_EMIT_SEQ) || (cmd == CMD_SORT_EMIT);
		rd_addr = addr_of(idx, (cmd == CMD_READ_NEXT) ? i_q + 1'b1 : i_q);
		mem_we = (cmd == CMD_SHIFT) || (cmd == CMD_SINGLE && do_app);
		wr_addr = addr_of(idx, (cmd == CMD_SHIFT) ? i_q : fl);
		wr_data = (cmd == CMD_SHIFT) ? rd_q : req_q.value;
	end

	always_comb begin
		stat.req_type = req_q.req_type;
		stat.multi = ex && (fl != '0) && (req_q.req_type == REQ_DELETE
			|| req_q.req_type == REQ_READ || req_q.req_type == REQ_SORTED);
		stat.i_end = (i_q == fl);
		stat.i_next_end = ({1'b0, i_q} + 1'b1) >= {1'b0, fl};
		stat.found = (rd_q == req_q.value);
		stat.k_end = ({1'b0, k_q} + 1'b1) == {1'b0, fl};
		stat.out_free = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd == CMD_READ || cmd == CMD_READ_NEXT) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				exists_q[s] <= 1'b0;
				size_q[s] <= '0;
				fill_q[s] <= '0;
			end
			rsp_valid_q <= 1'b0;
			i_q <= '0;
			k_q <= '0;
			best_ok_q <= 1'b0;
			has_last_q <= 1'b0;
		end else begin
			if (is_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_LOAD: begin
					i_q <= '0;
					k_q <= '0;
					best_ok_q <= 1'b0;
					has_last_q <= 1'b0;
				end
				CMD_SINGLE: begin
					if (do_create) begin
						exists_q[idx] <= 1'b1;
						size_q[idx] <= CW'(sd18);
						fill_q[idx] <= '0;
					end
					if (do_size) begin
						size_q[idx] <= new_size;
					end
					if (do_fill) begin
						fill_q[idx] <= new_fill;
					end
				end
				CMD_CMP: begin
					if (!stat.found) begin
						i_q <= i_q + 1'b1;
					end
				end
				CMD_SHIFT, CMD_EMIT_SEQ: begin
					i_q <= i_q + 1'b1;
				end
				CMD_DEL_DONE: begin
					fill_q[idx] <= fl - 1'b1;
				end
				CMD_SORT_CMP: begin
					if (cand && better) begin
						best_ok_q <= 1'b1;
					end
					i_q <= i_q + 1'b1;
				end
				CMD_SORT_EMIT: begin
					has_last_q <= 1'b1;
					best_ok_q <= 1'b0;
					i_q <= '0;
					k_q <= k_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			req_q <= req;
		end
		if (cmd == CMD_SORT_CMP && cand && better) begin
			best_v_q <= rd_q;
			best_i_q <= i_q;
		end
		if (cmd == CMD_SORT_EMIT) begin
			last_v_q <= best_v_q;
			last_i_q <= best_i_q;
		end
	end

	always_comb begin
		fw = 32'(fl);
		case (cmd)
			CMD_SINGLE: fw = 32'(fill_o);
			CMD_DEL_DONE: fw = 32'(fl - 1'b1);
			default: fw = 32'(fl);
		endcase
	end

	always_ff @(posedge clk) begin
		if (is_emit) begin
			rsp_q.fill_count <= fw[4:0];
			case (cmd)
				CMD_SINGLE: begin
					rsp_q.status <= st;
					rsp_q.data_word <= '0;
					rsp_q.last_result <= 1'b1;
				end
				CMD_NOT_FOUND: begin
					rsp_q.status <= ST_NOT_FOUND;
					rsp_q.data_word <= '0;
					rsp_q.last_result <= 1'b1;
				end
				CMD_EMIT_SEQ: begin
					rsp_q.status <= ST_OK;
					rsp_q.data_word <= rd_q;
					rsp_q.last_result <= stat.i_next_end;
				end
				CMD_SORT_EMIT: begin
					rsp_q.status <= ST_OK;
					rsp_q.data_word <= best_v_q;
					rsp_q.last_result <= stat.k_end;
				end
				default: begin
					rsp_q.status <= ST_OK;
					rsp_q.data_word <= '0;
					rsp_q.last_result <= 1'b1;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_emit && rsp_valid_q && rsp_stall))
		else $error("result overwritten while stalled");
	a_single_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_SINGLE |=> rsp_valid_q)
		else $error("single result not presented");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ex |-> fl <= sz)
		else $error("fill above size");
	a_sort_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_SORT_EMIT |-> best_ok_q)
		else $error("sorted emit without candidate");

endmodule

/* src/mslt_ctrl.sv */
`timescale 1ns / 1ps
module mslt_ctrl
	import mslt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_D_RD, S_D_CMP, S_S_RD, S_S_WR,
		S_R_RD, S_R_EMIT, S_Q_RD, S_Q_CMP, S_Q_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = CMD_NOP;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd = CMD_LOAD;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (!stat.multi) begin
					if (stat.out_free) begin
						cmd = CMD_SINGLE;
						state_d = S_IDLE;
					end
				end else if (stat.req_type == REQ_DELETE) begin
					state_d = S_D_RD;
				end else if (stat.req_type == REQ_READ) begin
					state_d = S_R_RD;
				end else begin
					state_d = S_Q_RD;
				end
			end
			S_D_RD: begin
				if (stat.i_end) begin
					if (stat.out_free) begin
						cmd = CMD_NOT_FOUND;
						state_d = S_IDLE;
					end
				end else begin
					cmd = CMD_READ;
					state_d = S_D_CMP;
				end
			end
			S_D_CMP: begin
				cmd = CMD_CMP;
				state_d = stat.found ? S_S_RD : S_D_RD;
			end
			S_S_RD: begin
				if (stat.i_next_end) begin
					if (stat.out_free) begin
						cmd = CMD_DEL_DONE;
						state_d = S_IDLE;
					end
				end else begin
					cmd = CMD_READ_NEXT;
					state_d = S_S_WR;
				end
			end
			S_S_WR: begin
				cmd = CMD_SHIFT;
				state_d = S_S_RD;
			end
			S_R_RD: begin
				cmd = CMD_READ;
				state_d = S_R_EMIT;
			end
			S_R_EMIT: begin
				if (stat.out_free) begin
					cmd = CMD_EMIT_SEQ;
					state_d = stat.i_next_end ? S_IDLE : S_R_RD;
				end
			end
			S_Q_RD: begin
				if (stat.i_end) begin
					state_d = S_Q_EMIT;
				end else begin
					cmd = CMD_READ;
					state_d = S_Q_CMP;
				end
			end
			S_Q_CMP: begin
				cmd = CMD_SORT_CMP;
				state_d = S_Q_RD;
			end
			S_Q_EMIT: begin
				if (stat.out_free) begin
					cmd = CMD_SORT_EMIT;
					state_d = stat.k_end ? S_IDLE : S_Q_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_LOAD |=> state_q == S_LOOK)
		else $error("load did not enter lookup");
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_CMP |-> $past(cmd) == CMD_READ)
		else $error("compare without read");
	a_shift_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_SHIFT |-> $past(cmd) == CMD_READ_NEXT)
		else $error("shift without read");

endmodule

/* src/multi_slot_bounded_list_table_top.sv */
`timescale 1ns / 1ps
// table of numbered slots, each holding a bounded list of signed words
// request channel: req_valid / req_stall / req; result channel: rsp_valid / rsp_stall / rsp
// a request is taken when valid is high and stall is low; one request is worked at a time
// req_stall stays high from the cycle after acceptance until the last result is registered
// single-result requests: the request is registered, then the result once the output is free
// read: each stored value is read, then emitted; the store has one registered read port
// delete: search reads and compares each entry, then later entries shift down; then the result
// sorted read: each result rescans the whole slot for the next smallest value
// results sit in an output register; while rsp_stall is high it holds, and the next result waits
// reset clears every slot (no slot exists); the value store itself is not cleared
module multi_slot_bounded_list_table_top
	import mslt_pkg::*;
#(
	parameter int NUM_SLOTS = 10,
	parameter int SLOT_CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mslt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mslt_dp #(
		.NUM_SLOTS     (NUM_SLOTS),
		.SLOT_CAPACITY (SLOT_CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
